// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthands for clocked concurrent assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication built on the clocked form
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

`endif

// ===== rtl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// shared types, codes and sizes of the priority run queue
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int QUEUE_DEPTH = 32;
  // entries per first-level group of the tail select tree
  localparam int GROUP = 16;

  localparam logic [1:0] FUNC_ENQ   = 2'd0;
  localparam logic [1:0] FUNC_PICK  = 2'd1;
  localparam logic [1:0] FUNC_STEAL = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] task_id;
    logic [7:0] task_prio;
    logic       insert_front;
    logic       already_queued;
    logic       task_is_idle;
    logic       was_runnable;
    logic [7:0] current_prio;
    logic       current_is_idle;
  } prq_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_task_id;
    logic [7:0] out_task_prio;
    logic       resched_req;
    logic       mark_current_front;
    logic [5:0] queue_count;
  } prq_out_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } entry_t;

  typedef struct packed {
    logic load;    // latch the accepted word
    logic look;    // register the first level of the tail select
    logic commit;  // update the queue and the result register
  } cmd_t;

endpackage

// ===== rtl/priority_run_queue_core.sv =====
// ----------------------------------------------------------------------------
// priority_run_queue_core
// sorted task run queue with enqueue, pick head and steal tail
// ----------------------------------------------------------------------------
// sequence: a word is taken, the first level of the tail select tree is
//   registered in the look-up step, then the commit step writes the result
//   word; the commit waits only while a held result word is not taken, and
//   the next word may be taken in the commit step
// reset: synchronous; queue empty, preemption checks enabled, no result held
// ----------------------------------------------------------------------------
module priority_run_queue_core #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  prq_pkg::prq_in_t   req,
  // result channel
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output prq_pkg::prq_out_t  rsp,
  // preempt_enable register
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  // command word from the sequencer to the datapath
  prq_pkg::cmd_t cmd;

  // sequencer: takes a word, registers the tail look-up, then
  // commits; the next word may be taken in the commit cycle so long as the
  // result register is free or being emptied
  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // datapath: the queue is a chain of cells kept sorted by priority;
  // insert and head removal shift the chain in one step, the tail is read
  // through a two-level registered select tree
  prq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/prq_ctrl.sv =====
// ----------------------------------------------------------------------------
// prq_ctrl
// sequencer of the run queue: accept, look-up, commit
// ----------------------------------------------------------------------------
module prq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output prq_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOK   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   commit_ok;
  logic   accept;

  // commit only once the result register is free
  assign commit_ok = (state == S_COMMIT) && (!rsp_valid || rsp_ready);
  assign req_ready = (state == S_IDLE) || commit_ok;
  assign accept    = req_valid && req_ready;

  assign cmd.load   = accept;
  assign cmd.look   = (state == S_LOOK);
  assign cmd.commit = commit_ok;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit_ok) state_next = accept ? S_LOOK : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_ok) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/prq_dpath.sv =====
// ----------------------------------------------------------------------------
// prq_dpath
// sorted cell chain, fill count, tail select tree and result register
// ----------------------------------------------------------------------------
module prq_dpath #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  prq_pkg::cmd_t      cmd,
  input  prq_pkg::prq_in_t   req,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output prq_pkg::prq_out_t  rsp
);

  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int NGRP = (QUEUE_DEPTH + prq_pkg::GROUP - 1) / prq_pkg::GROUP;

  prq_pkg::prq_in_t  item;
  prq_pkg::entry_t   cells [QUEUE_DEPTH];
  prq_pkg::entry_t   cells_next [QUEUE_DEPTH];
  prq_pkg::entry_t   grp [NGRP];
  prq_pkg::entry_t   grp_next [NGRP];
  logic [CW-1:0]     count, count_next;
  logic              preempt;
  prq_pkg::prq_out_t rsp_q, rsp_next;

  assign rsp = rsp_q;

  // first level of the tail select: one pick per group of cells
  always_comb begin
    int tail;
    tail = int'(count) - 1;
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < prq_pkg::GROUP; k++) begin
        if ((g * prq_pkg::GROUP + k < QUEUE_DEPTH) && (g * prq_pkg::GROUP + k == tail))
          grp_next[g] = cells[g * prq_pkg::GROUP + k];
      end
    end
  end

  // operation result and next chain contents
  always_comb begin
    logic [QUEUE_DEPTH-1:0] ahead;
    prq_pkg::entry_t        tail_ent;
    prq_pkg::entry_t        new_ent;
    logic [CW+5:0]          cnt_ext;
    int                     tsel;

    tsel = (int'(count) - 1) / prq_pkg::GROUP;
    tail_ent = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (g == tsel) tail_ent = grp[g];
    end

    new_ent.id   = item.task_id;
    new_ent.prio = item.task_prio;

    // cells that stay ahead of the new entry form a prefix of the chain
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ahead[i] = (i < int'(count)) &&
                 (item.insert_front ? (cells[i].prio < item.task_prio)
                                    : (cells[i].prio <= item.task_prio));
    end

    cells_next = cells;
    count_next = count;
    rsp_next   = '0;
    rsp_next.status = prq_pkg::ST_DONE;

    case (item.func)
      prq_pkg::FUNC_ENQ: begin
        if (item.already_queued || item.task_is_idle) begin
          rsp_next.status = prq_pkg::ST_IGNORED;
        end else if (count == CW'(QUEUE_DEPTH)) begin
          rsp_next.status = prq_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
          if (!ahead[0]) cells_next[0] = new_ent;
          for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (!ahead[i]) cells_next[i] = ahead[i-1] ? new_ent : cells[i-1];
          end
          rsp_next.resched_req = !item.was_runnable && preempt &&
                                 !item.current_is_idle &&
                                 (item.task_prio < item.current_prio);
          rsp_next.mark_current_front = rsp_next.resched_req;
        end
      end
      prq_pkg::FUNC_PICK: begin
        if (count == '0) begin
          rsp_next.status = prq_pkg::ST_EMPTY;
        end else begin
          rsp_next.out_task_id   = cells[0].id;
          rsp_next.out_task_prio = cells[0].prio;
          count_next = count - 1'b1;
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) cells_next[i] = cells[i+1];
        end
      end
      prq_pkg::FUNC_STEAL: begin
        if (count == '0) begin
          rsp_next.status = prq_pkg::ST_EMPTY;
        end else begin
          rsp_next.out_task_id   = tail_ent.id;
          rsp_next.out_task_prio = tail_ent.prio;
          count_next = count - 1'b1;
        end
      end
      default: begin
        rsp_next.status = prq_pkg::ST_IGNORED;
      end
    endcase

    cnt_ext = {6'b0, count_next};
    rsp_next.queue_count = cnt_ext[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      preempt <= 1'b1;
    end else begin
      if (cfg_we) preempt <= cfg_wdata;
      if (cmd.commit) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
    if (cmd.look) grp <= grp_next;
    if (cmd.commit) begin
      cells <= cells_next;
      rsp_q <= rsp_next;
    end
  end

endmodule

// ===== rtl/prq_checker.sv =====
// ----------------------------------------------------------------------------
// prq_checker
// port-level checks of the run queue, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prq_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input prq_pkg::prq_out_t  rsp
);

  // a stalled result word holds
  `ASSERT_CLK(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)), "result word changed while stalled")

  // a new result only follows a taken request that has passed the look-up and commit steps
  `ASSERT_IMP(a_rsp_latency, clk, rst, $rose(rsp_valid), $past(req_valid && req_ready, 3), "result without matching request")

  // an empty queue returns no entry
  `ASSERT_IMP(a_empty_zero, clk, rst, rsp_valid && (rsp.status == prq_pkg::ST_EMPTY), (rsp.out_task_id == 8'd0) && (rsp.out_task_prio == 8'd0), "entry returned from empty queue")

  // resched request only on a completed enqueue, and mirrored by the mark
  `ASSERT_IMP(a_resched, clk, rst, rsp_valid && (rsp.resched_req || rsp.mark_current_front), (rsp.status == prq_pkg::ST_DONE) && (rsp.resched_req == rsp.mark_current_front), "bad resched flags")

endmodule

bind priority_run_queue_core prq_checker u_prq_checker (.*);

// ===== dv/tb_priority_run_queue_core.sv =====
// ----------------------------------------------------------------------------
// tb_priority_run_queue_core
// self-checking bench for the sorted task run queue: a clocked driver feeds
// request words from a pending queue, a clocked monitor checks every result
// word against a behavioural copy of the queue kept in step at acceptance
// ----------------------------------------------------------------------------
module tb_priority_run_queue_core;

  localparam int QD = prq_pkg::QUEUE_DEPTH;
  // operation code with no meaning, answered as ignored
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // cycles with no word moving on either channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // drain time after the last result, well beyond the block latency
  localparam int TAIL_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  prq_pkg::prq_in_t  req = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  prq_pkg::prq_out_t rsp;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  // request words waiting for the driver, result words waiting for the monitor
  prq_pkg::prq_in_t  pending_words[$];
  prq_pkg::prq_out_t expected_words[$];

  // words handed to the driver and not yet checked
  int outstanding = 0;
  int stall_cycles = 0;
  bit failed = 1'b0;
  // no idling on either side while set
  bit calm = 1'b0;

  // behavioural copy of the run queue and the preemption register
  prq_pkg::entry_t runq_slots[QD];
  int              runq_count = 0;
  bit              preempt_on = 1'b1;

  priority_run_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one random idle decision, about 27 in a hundred outside calm stretches
  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 27);
  endfunction

  // applies one request word to the queue copy and returns its result word
  function automatic prq_pkg::prq_out_t runq_apply(prq_pkg::prq_in_t w);
    prq_pkg::prq_out_t o;
    int pos;
    int i;
    o = '0;
    o.status = prq_pkg::ST_DONE;
    case (w.func)
      prq_pkg::FUNC_ENQ: begin
        if (w.already_queued || w.task_is_idle) begin
          o.status = prq_pkg::ST_IGNORED;
        end else if (runq_count >= QD) begin
          o.status = prq_pkg::ST_FULL;
        end else begin
          // insert-front stops at the first equal priority, else after the run of them
          pos = 0;
          while (pos < runq_count &&
                 (w.insert_front ? (runq_slots[pos].prio < w.task_prio)
                                 : (runq_slots[pos].prio <= w.task_prio)))
            pos++;
          for (i = runq_count; i > pos; i--) runq_slots[i] = runq_slots[i-1];
          runq_slots[pos].id   = w.task_id;
          runq_slots[pos].prio = w.task_prio;
          runq_count++;
          if (!w.was_runnable && preempt_on && !w.current_is_idle &&
              (w.task_prio < w.current_prio)) begin
            o.resched_req        = 1'b1;
            o.mark_current_front = 1'b1;
          end
        end
      end
      prq_pkg::FUNC_PICK, prq_pkg::FUNC_STEAL: begin
        if (runq_count == 0) begin
          o.status = prq_pkg::ST_EMPTY;
        end else if (w.func == prq_pkg::FUNC_PICK) begin
          o.out_task_id   = runq_slots[0].id;
          o.out_task_prio = runq_slots[0].prio;
          runq_count--;
          for (i = 0; i < runq_count; i++) runq_slots[i] = runq_slots[i+1];
        end else begin
          runq_count--;
          o.out_task_id   = runq_slots[runq_count].id;
          o.out_task_prio = runq_slots[runq_count].prio;
        end
      end
      default: begin
        o.status = prq_pkg::ST_IGNORED;
      end
    endcase
    o.queue_count = runq_count[5:0];
    return o;
  endfunction

  function automatic prq_pkg::prq_in_t mk(logic [1:0] f, logic [7:0] id, logic [7:0] prio,
                                          bit front, bit queued, bit tidle, bit runn,
                                          logic [7:0] cprio, bit cidle);
    prq_pkg::prq_in_t w;
    w.func            = f;
    w.task_id         = id;
    w.task_prio       = prio;
    w.insert_front    = front;
    w.already_queued  = queued;
    w.task_is_idle    = tidle;
    w.was_runnable    = runn;
    w.current_prio    = cprio;
    w.current_is_idle = cidle;
    return w;
  endfunction

  // random word: mostly clean enqueues and removals, some noise
  function automatic prq_pkg::prq_in_t rand_word(int enq_pct);
    prq_pkg::prq_in_t w;
    logic [31:0]      raw;
    int r;
    raw = $urandom;
    w = raw[$bits(prq_pkg::prq_in_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < enq_pct) begin
      w.func = prq_pkg::FUNC_ENQ;
      if ($urandom_range(0, 9) != 0) begin
        w.already_queued = 1'b0;
        w.task_is_idle   = 1'b0;
      end
    end else if (r < 97) begin
      w.func = $urandom_range(0, 1) ? prq_pkg::FUNC_PICK : prq_pkg::FUNC_STEAL;
    end else begin
      w.func = FUNC_UNUSED;
    end
    // a few coarse priority levels give plenty of equal-priority runs
    if ($urandom_range(0, 1)) w.task_prio = 8'($urandom_range(0, 5) * 51);
    if ($urandom_range(0, 3) == 0) w.current_prio = 8'($urandom_range(0, 5) * 51);
    return w;
  endfunction

  // register write, only issued while nothing is outstanding
  task automatic write_preempt(bit v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    preempt_on = v;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic push_word(prq_pkg::prq_in_t w);
    pending_words.push_back(w);
    outstanding++;
  endtask

  task automatic random_phase(bit pe, int n, int enq_pct, bit quiet);
    write_preempt(pe);
    calm = quiet;
    repeat (n) push_word(rand_word(enq_pct));
    wait_drained();
    calm = 1'b0;
  endtask

  // driver: predicts each word as it is taken, then offers the next one
  always @(posedge clk) begin : driver
    prq_pkg::prq_in_t nxt;
    logic hold;
    if (!rst) begin
      hold = req_valid && !req_ready;
      if (req_valid && req_ready) expected_words.push_back(runq_apply(req));
      if (!hold) begin
        if (pending_words.size() != 0 && !take_gap()) begin
          nxt = pending_words.pop_front();
          req       <= nxt;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] exp, logic [7:0] got);
    if (got !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      failed = 1'b1;
    end
  endtask

  // monitor: compares each taken result word with the oldest expectation
  always @(posedge clk) begin : monitor
    prq_pkg::prq_out_t exp;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation waiting: %h", rsp);
          failed = 1'b1;
        end else begin
          exp = expected_words.pop_front();
          check_field("status", 8'(exp.status), 8'(rsp.status));
          check_field("out_task_id", exp.out_task_id, rsp.out_task_id);
          check_field("out_task_prio", exp.out_task_prio, rsp.out_task_prio);
          check_field("resched_req", 8'(exp.resched_req), 8'(rsp.resched_req));
          check_field("mark_current_front", 8'(exp.mark_current_front),
                      8'(rsp.mark_current_front));
          check_field("queue_count", 8'(exp.queue_count), 8'(rsp.queue_count));
          outstanding--;
        end
      end
      rsp_ready <= !take_gap();
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("priority_run_queue_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, preemption on
    write_preempt(1'b1);
    push_word(mk(prq_pkg::FUNC_PICK,  8'd0,   8'd0,   0, 0, 0, 0, 8'd0,   0)); // pick on empty
    push_word(mk(prq_pkg::FUNC_STEAL, 8'd255, 8'd255, 1, 1, 1, 1, 8'd255, 1)); // steal on empty
    push_word(mk(FUNC_UNUSED,         8'd77,  8'd9,   1, 0, 0, 0, 8'd200, 0)); // unused code
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd5,   8'd3,   0, 1, 0, 0, 8'd200, 0)); // already queued
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd6,   8'd3,   0, 0, 1, 0, 8'd200, 0)); // idle task
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd0,   8'd255, 0, 0, 0, 0, 8'd255, 0)); // equal to current
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd255, 8'd0,   0, 0, 0, 0, 8'd255, 0)); // preempts
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd10,  8'd100, 0, 0, 0, 0, 8'd101, 1)); // current is idle
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd11,  8'd100, 0, 0, 0, 1, 8'd200, 0)); // was runnable
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd12,  8'd100, 1, 0, 0, 0, 8'd200, 0)); // front of equals
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd13,  8'd100, 0, 0, 0, 0, 8'd200, 0)); // back of equals
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd14,  8'd255, 1, 0, 0, 0, 8'd0,   0)); // front at tail
    push_word(mk(prq_pkg::FUNC_PICK,  8'd0,   8'd0,   0, 0, 0, 0, 8'd0,   0));
    push_word(mk(prq_pkg::FUNC_STEAL, 8'd0,   8'd0,   0, 0, 0, 0, 8'd0,   0));
    push_word(mk(prq_pkg::FUNC_PICK,  8'd0,   8'd0,   0, 0, 0, 0, 8'd0,   0));
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd20,  8'd0,   0, 1, 1, 0, 8'd255, 0)); // both ignores
    wait_drained();

    // directed, preemption off, then drain to empty
    write_preempt(1'b0);
    push_word(mk(prq_pkg::FUNC_ENQ,   8'd30,  8'd0,   0, 0, 0, 0, 8'd255, 0));
    repeat (5) push_word(mk(prq_pkg::FUNC_PICK, 8'd0, 8'd0, 0, 0, 0, 0, 8'd0, 0));
    push_word(mk(prq_pkg::FUNC_STEAL, 8'd0,   8'd0,   0, 0, 0, 0, 8'd0,   0));
    wait_drained();

    // random phases: fill towards full, drain towards empty, balanced mixes
    random_phase(1'b0, 320, 80, 1'b0);
    random_phase(1'b1, 320, 25, 1'b0);
    random_phase(1'b1, 250, 55, 1'b1);
    random_phase(1'b0, 320, 55, 1'b0);
    random_phase(1'b1, 300, 85, 1'b0);
    random_phase(1'b1, 320, 20, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed && expected_words.size() == 0) begin
      $display("priority_run_queue_core regression: pass");
    end else begin
      $display("priority_run_queue_core regression: fail");
    end
    $finish;
  end

endmodule
